// ===== rtl/core/bankers_request_safety_check_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the resource guard checker
// ---------------------------------------------------------------------------
`ifndef BANKERS_REQUEST_SAFETY_CHECK_ASSERT_SVH
`define BANKERS_REQUEST_SAFETY_CHECK_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define BRSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that also holds during reset.
`define BRSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/brsc_pkg.sv =====
// ---------------------------------------------------------------------------
// brsc_pkg
// Command, status and register codes of the resource guard.
// ---------------------------------------------------------------------------
`default_nettype none

package brsc_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_AVAIL = 3'd0,
    CMD_LOAD_MAX   = 3'd1,
    CMD_LOAD_ALLOC = 3'd2,
    CMD_REQUEST    = 3'd3,
    CMD_READ       = 3'd4
  } brsc_cmd_e;

  typedef enum logic [2:0] {
    ST_GRANT  = 3'd0,
    ST_RETIRE = 3'd1,
    ST_NEED   = 3'd2,
    ST_AVAIL  = 3'd3,
    ST_UNSAFE = 3'd4,
    ST_READ   = 3'd5
  } brsc_status_e;

  typedef enum logic [1:0] {
    SEL_AVAIL = 2'd0,
    SEL_MAX   = 2'd1,
    SEL_ALLOC = 2'd2,
    SEL_NEED  = 2'd3
  } brsc_sel_e;

  typedef enum logic [1:0] {
    CFG_NUM_PROCESSES = 2'd0,
    CFG_NUM_RESOURCES = 2'd1
  } brsc_cfg_e;

endpackage

`default_nettype wire

// ===== rtl/core/bankers_request_safety_check.sv =====
// ---------------------------------------------------------------------------
// bankers_request_safety_check
// Resource guard that grants requests only when a safe order exists.
// ---------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. Loads of
// maximum and allocation do a read-modify-write of one table row, a load of
// available and a non-final request element complete on acceptance, and a
// read registers its operand first and then its result on the outputs.
// A final request element starts the check. With m resources in use and n
// processes it runs a need check over the m resources, passes over the n
// processes that test each one and complete those that can finish, a commit
// over the m resources and, on a grant, the results of the safe order;
// every table access goes through the entry memory, whose read is registered.
// Results appear on the output registers for one cycle with result_valid_o;
// the receiver cannot stall, so no result is held back. A granted request
// emits its safe order, one result per process, last_of_run_o on the
// final one; every other request or read yields one result.
// Reset clears available units, retired flags and control state; the entry
// memory has no reset, a valid bit per entry cleared at reset makes an entry
// read as zero until it is written.
// ---------------------------------------------------------------------------
`default_nettype none

module bankers_request_safety_check #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int UNIT_BITS     = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] cmd_i,
  input  logic [3:0] process_i,
  input  logic [2:0] resource_i,
  input  logic [7:0] amount_i,
  input  logic [1:0] table_select_i,
  input  logic       final_element_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_wdata_i,
  output logic       result_valid_o,
  output logic [2:0] status_o,
  output logic [3:0] order_process_o,
  output logic [7:0] read_value_o,
  output logic       last_of_run_o
);
  import brsc_pkg::*;

  localparam int PW    = $clog2(MAX_PROCESSES);
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int U     = UNIT_BITS;
  localparam int DEPTH = 2 ** (PW + RW);
  localparam int SEQD  = 2 ** PW;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_LOAD    = 16'h0002,
    S_READ    = 16'h0004,
    S_REQ     = 16'h0008,
    S_CK_RD   = 16'h0010,
    S_CK_EV   = 16'h0020,
    S_TR_INIT = 16'h0040,
    S_PR_SEL  = 16'h0080,
    S_PC_RD   = 16'h0100,
    S_PC_EV   = 16'h0200,
    S_PA_RD   = 16'h0400,
    S_PA_EV   = 16'h0800,
    S_CM_RD   = 16'h1000,
    S_CM_EV   = 16'h2000,
    S_EM_RD   = 16'h4000,
    S_EM_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // entry memory: {max, alloc, need}
  logic [3*U-1:0] ent_mem [DEPTH];
  logic [3*U-1:0] ent_rd_q;
  logic [3*U-1:0] ent_rd;
  logic [DEPTH-1:0] ent_vld_q;
  logic           ent_rd_vld_q;
  logic [PW+RW-1:0] ent_raddr, ent_waddr;
  logic [3*U-1:0] ent_wdata;
  logic           ent_we;

  // safe order memory
  logic [PW-1:0] seq_mem [SEQD];
  logic [PW-1:0] seq_rd_q;
  logic          seq_we;

  logic [PW-1:0] pid_q, pid_d;
  logic [RW-1:0] r_q, r_d;
  logic [PW:0]   i_q, i_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          over_q, over_d;
  logic          progress_q, progress_d;
  logic          init_q, init_d;
  logic          req_bad_q, req_bad_d;
  logic          ld_alloc_q, ld_alloc_d;
  logic [U-1:0]  amt_q, amt_d;
  logic [1:0]    sel_q, sel_d;
  logic          rd_rok_q, rd_rok_d;
  logic          rd_tok_q, rd_tok_d;

  logic [U-1:0]  avail_q [MAX_RESOURCES];
  logic [U-1:0]  avail_d [MAX_RESOURCES];
  logic [U-1:0]  pend_q  [MAX_RESOURCES];
  logic [U-1:0]  pend_d  [MAX_RESOURCES];
  logic [U:0]    trial_q [MAX_RESOURCES];
  logic [U:0]    trial_d [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] retired_q, retired_d;
  logic [MAX_PROCESSES-1:0] done_q, done_d;

  logic [4:0] nproc_q;
  logic [3:0] nres_q;

  logic       vld_q, vld_d;
  logic [2:0] status_q, status_d;
  logic [3:0] order_q, order_d;
  logic [7:0] readv_q, readv_d;
  logic       last_q, last_d;

  // decoded inputs
  logic [PW+3:0] proc_ext;
  logic [RW+2:0] res_ext;
  logic [U+7:0]  amt_ext;
  logic [PW-1:0] proc_t;
  logic [RW-1:0] res_t;
  logic [U-1:0]  amt_in;
  logic          pok, rok;

  assign proc_ext = {{PW{1'b0}}, process_i};
  assign res_ext  = {{RW{1'b0}}, resource_i};
  assign amt_ext  = {{U{1'b0}}, amount_i};
  assign proc_t   = proc_ext[PW-1:0];
  assign res_t    = res_ext[RW-1:0];
  assign amt_in   = amt_ext[U-1:0];
  assign pok      = (int'(process_i) < MAX_PROCESSES);
  assign rok      = (int'(resource_i) < MAX_RESOURCES);

  // clamped register values
  logic [PW+5:0] nproc_ext;
  logic [RW+4:0] nres_ext;
  logic [PW:0]   n_eff;
  logic [RW:0]   m_eff;

  assign nproc_ext = {{(PW+1){1'b0}}, nproc_q};
  assign nres_ext  = {{(RW+1){1'b0}}, nres_q};

  always_comb begin
    if (nproc_q == '0) begin
      n_eff = (PW+1)'(1);
    end else if (int'(nproc_q) > MAX_PROCESSES) begin
      n_eff = (PW+1)'(MAX_PROCESSES);
    end else begin
      n_eff = nproc_ext[PW:0];
    end
    if (nres_q == '0) begin
      m_eff = (RW+1)'(1);
    end else if (int'(nres_q) > MAX_RESOURCES) begin
      m_eff = (RW+1)'(MAX_RESOURCES);
    end else begin
      m_eff = nres_ext[RW:0];
    end
  end

  // datapath terms
  logic [U-1:0] e_max, e_alloc, e_need;
  logic [U-1:0] pend_r, avail_r, pend_i, nd;
  logic [U:0]   trial_r, trial_sat;
  logic [U+2:0] trial_sum;
  logic [U:0]   avail_sum;
  logic [U-1:0] avail_sat;
  logic         m_last, is_pid, remaining;
  logic [U-1:0] ld_max, ld_alloc, ld_need;
  logic [U+7:0] read_ext;
  logic [U-1:0] read_v;
  logic [PW+3:0] seq_ext;

  // an entry never written reads as zero
  assign ent_rd    = ent_rd_vld_q ? ent_rd_q : '0;
  assign e_max     = ent_rd[3*U-1:2*U];
  assign e_alloc   = ent_rd[2*U-1:U];
  assign e_need    = ent_rd[U-1:0];
  assign pend_r    = pend_q[r_q];
  assign avail_r   = avail_q[r_q];
  assign trial_r   = trial_q[r_q];
  assign is_pid    = (i_q[PW-1:0] == pid_q);
  assign pend_i    = is_pid ? pend_r : '0;
  assign nd        = e_need - pend_i;
  assign trial_sum = {2'b00, trial_r} + {3'b000, e_alloc} + {3'b000, pend_i};
  assign trial_sat = (trial_sum > {2'b00, {(U+1){1'b1}}}) ? {(U+1){1'b1}} : trial_sum[U:0];
  assign avail_sum = {1'b0, avail_r} + {1'b0, e_alloc};
  assign avail_sat = avail_sum[U] ? {U{1'b1}} : avail_sum[U-1:0];
  assign m_last    = ({1'b0, r_q} == (m_eff - (RW+1)'(1)));
  assign seq_ext   = {4'b0000, seq_rd_q};

  always_comb begin
    remaining = 1'b0;
    for (int j = 0; j < MAX_PROCESSES; j++) begin
      if (((PW+1)'(j) < n_eff) && !retired_q[j] && !done_q[j]) begin
        remaining = 1'b1;
      end
    end
  end

  always_comb begin
    ld_max   = ld_alloc_q ? e_max : amt_q;
    ld_alloc = ld_alloc_q ? amt_q : e_alloc;
    ld_need  = (ld_max > ld_alloc) ? (ld_max - ld_alloc) : '0;
  end

  always_comb begin
    read_v = '0;
    if (sel_q == SEL_AVAIL) begin
      read_v = rd_rok_q ? avail_r : '0;
    end else if (rd_tok_q) begin
      case (sel_q)
        SEL_MAX:   read_v = e_max;
        SEL_ALLOC: read_v = e_alloc;
        default:   read_v = e_need;
      endcase
    end
    read_ext = {8'h00, read_v};
  end

  // memory addressing
  always_comb begin
    if (state_q == S_IDLE) begin
      ent_raddr = {proc_t, res_t};
    end else if ((state_q == S_PC_RD) || (state_q == S_PA_RD)) begin
      ent_raddr = {i_q[PW-1:0], r_q};
    end else begin
      ent_raddr = {pid_q, r_q};
    end
    ent_waddr = {pid_q, r_q};
  end

  always_comb begin
    state_d    = state_q;
    pid_d      = pid_q;
    r_d        = r_q;
    i_d        = i_q;
    cnt_d      = cnt_q;
    over_d     = over_q;
    progress_d = progress_q;
    init_d     = init_q;
    req_bad_d  = req_bad_q;
    ld_alloc_d = ld_alloc_q;
    amt_d      = amt_q;
    sel_d      = sel_q;
    rd_rok_d   = rd_rok_q;
    rd_tok_d   = rd_tok_q;
    avail_d    = avail_q;
    pend_d     = pend_q;
    trial_d    = trial_q;
    retired_d  = retired_q;
    done_d     = done_q;
    vld_d      = 1'b0;
    status_d   = status_q;
    order_d    = order_q;
    readv_d    = readv_q;
    last_d     = last_q;
    ent_we     = 1'b0;
    ent_wdata  = ent_rd;
    seq_we     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_LOAD_AVAIL: begin
              if (rok) avail_d[res_t] = amt_in;
            end
            CMD_LOAD_MAX, CMD_LOAD_ALLOC: begin
              if (pok && rok) begin
                pid_d      = proc_t;
                r_d        = res_t;
                amt_d      = amt_in;
                ld_alloc_d = (cmd_i == CMD_LOAD_ALLOC);
                state_d    = S_LOAD;
              end
            end
            CMD_REQUEST: begin
              if (rok) pend_d[res_t] = amt_in;
              if (final_element_i) begin
                pid_d     = proc_t;
                req_bad_d = (proc_ext >= {3'b000, n_eff});
                state_d   = S_REQ;
              end
            end
            CMD_READ: begin
              pid_d    = proc_t;
              r_d      = res_t;
              sel_d    = table_select_i;
              rd_rok_d = rok;
              rd_tok_d = pok && rok;
              state_d  = S_READ;
            end
            default: ;
          endcase
        end
      end

      S_LOAD: begin
        ent_we    = 1'b1;
        ent_wdata = {ld_max, ld_alloc, ld_need};
        state_d   = S_IDLE;
      end

      S_READ: begin
        vld_d    = 1'b1;
        status_d = ST_READ;
        order_d  = '0;
        readv_d  = read_ext[7:0];
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end

      S_REQ: begin
        if (req_bad_q || retired_q[pid_q]) begin
          vld_d    = 1'b1;
          status_d = ST_NEED;
          order_d  = '0;
          readv_d  = '0;
          last_d   = 1'b1;
          for (int j = 0; j < MAX_RESOURCES; j++) pend_d[j] = '0;
          state_d  = S_IDLE;
        end else begin
          r_d     = '0;
          over_d  = 1'b1;
          state_d = S_CK_RD;
        end
      end

      S_CK_RD: state_d = S_CK_EV;

      S_CK_EV: begin
        if ((pend_r > e_need) || (pend_r > avail_r)) begin
          vld_d    = 1'b1;
          status_d = (pend_r > e_need) ? ST_NEED : ST_AVAIL;
          order_d  = '0;
          readv_d  = '0;
          last_d   = 1'b1;
          for (int j = 0; j < MAX_RESOURCES; j++) pend_d[j] = '0;
          state_d  = S_IDLE;
        end else begin
          trial_d[r_q] = {1'b0, avail_r - pend_r};
          over_d       = over_q && (e_need == pend_r);
          if (m_last) begin
            r_d     = '0;
            state_d = S_TR_INIT;
          end else begin
            r_d     = r_q + RW'(1);
            state_d = S_CK_RD;
          end
        end
      end

      S_TR_INIT: begin
        done_d = '0;
        cnt_d  = '0;
        r_d    = '0;
        if (over_q) begin
          // requester finishes first: release its whole allocation
          i_d     = {1'b0, pid_q};
          init_d  = 1'b1;
          state_d = S_PA_RD;
        end else begin
          i_d        = '0;
          progress_d = 1'b0;
          state_d    = S_PR_SEL;
        end
      end

      S_PR_SEL: begin
        if (i_q >= n_eff) begin
          if (!remaining) begin
            r_d     = '0;
            state_d = S_CM_RD;
          end else if (!progress_q) begin
            vld_d    = 1'b1;
            status_d = ST_UNSAFE;
            order_d  = '0;
            readv_d  = '0;
            last_d   = 1'b1;
            for (int j = 0; j < MAX_RESOURCES; j++) pend_d[j] = '0;
            state_d  = S_IDLE;
          end else begin
            i_d        = '0;
            progress_d = 1'b0;
          end
        end else if (!retired_q[i_q[PW-1:0]] && !done_q[i_q[PW-1:0]]) begin
          r_d     = '0;
          state_d = S_PC_RD;
        end else begin
          i_d = i_q + (PW+1)'(1);
        end
      end

      S_PC_RD: state_d = S_PC_EV;

      S_PC_EV: begin
        if ({1'b0, nd} > trial_r) begin
          i_d     = i_q + (PW+1)'(1);
          state_d = S_PR_SEL;
        end else if (m_last) begin
          r_d     = '0;
          state_d = S_PA_RD;
        end else begin
          r_d     = r_q + RW'(1);
          state_d = S_PC_RD;
        end
      end

      S_PA_RD: state_d = S_PA_EV;

      S_PA_EV: begin
        trial_d[r_q] = trial_sat;
        if (m_last) begin
          done_d[i_q[PW-1:0]] = 1'b1;
          seq_we              = 1'b1;
          cnt_d               = cnt_q + (PW+1)'(1);
          if (init_q) begin
            init_d     = 1'b0;
            i_d        = '0;
            progress_d = 1'b0;
          end else begin
            i_d        = i_q + (PW+1)'(1);
            progress_d = 1'b1;
          end
          state_d = S_PR_SEL;
        end else begin
          r_d     = r_q + RW'(1);
          state_d = S_PA_RD;
        end
      end

      S_CM_RD: state_d = S_CM_EV;

      S_CM_EV: begin
        ent_we = 1'b1;
        if (over_q) begin
          ent_wdata      = {e_max, {U{1'b0}}, e_need - pend_r};
          avail_d[r_q]   = avail_sat;
        end else begin
          ent_wdata      = {e_max, e_alloc + pend_r, e_need - pend_r};
          avail_d[r_q]   = avail_r - pend_r;
        end
        if (m_last) begin
          if (over_q) retired_d[pid_q] = 1'b1;
          i_d     = '0;
          state_d = S_EM_RD;
        end else begin
          r_d     = r_q + RW'(1);
          state_d = S_CM_RD;
        end
      end

      S_EM_RD: state_d = S_EM_OUT;

      S_EM_OUT: begin
        vld_d    = 1'b1;
        status_d = over_q ? ST_RETIRE : ST_GRANT;
        order_d  = seq_ext[3:0];
        readv_d  = '0;
        last_d   = ((i_q + (PW+1)'(1)) == cnt_q);
        i_d      = i_q + (PW+1)'(1);
        if ((i_q + (PW+1)'(1)) == cnt_q) begin
          for (int j = 0; j < MAX_RESOURCES; j++) pend_d[j] = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_EM_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd_q     <= ent_mem[ent_raddr];
    ent_rd_vld_q <= ent_vld_q[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (seq_we) seq_mem[cnt_q[PW-1:0]] <= i_q[PW-1:0];
    seq_rd_q <= seq_mem[i_q[PW-1:0]];
  end

  // control and committed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      retired_q  <= '0;
      done_q     <= '0;
      vld_q      <= 1'b0;
      nproc_q    <= 5'd16;
      nres_q     <= 4'd8;
      progress_q <= 1'b0;
      init_q     <= 1'b0;
      ent_vld_q  <= '0;
      for (int j = 0; j < MAX_RESOURCES; j++) avail_q[j] <= '0;
    end else begin
      state_q    <= state_d;
      retired_q  <= retired_d;
      done_q     <= done_d;
      vld_q      <= vld_d;
      progress_q <= progress_d;
      init_q     <= init_d;
      avail_q    <= avail_d;
      if (ent_we) ent_vld_q[ent_waddr] <= 1'b1;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_NUM_PROCESSES) nproc_q <= cfg_wdata_i;
        if (cfg_index_i == CFG_NUM_RESOURCES) nres_q  <= cfg_wdata_i[3:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pid_q      <= pid_d;
    r_q        <= r_d;
    i_q        <= i_d;
    cnt_q      <= cnt_d;
    over_q     <= over_d;
    req_bad_q  <= req_bad_d;
    ld_alloc_q <= ld_alloc_d;
    amt_q      <= amt_d;
    sel_q      <= sel_d;
    rd_rok_q   <= rd_rok_d;
    rd_tok_q   <= rd_tok_d;
    pend_q     <= pend_d;
    trial_q    <= trial_d;
    status_q   <= status_d;
    order_q    <= order_d;
    readv_q    <= readv_d;
    last_q     <= last_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = vld_q;
  assign status_o        = status_q;
  assign order_process_o = order_q;
  assign read_value_o    = readv_q;
  assign last_of_run_o   = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/brsc_checker.sv =====
// ---------------------------------------------------------------------------
// brsc_checker
// Port-level checks of the resource guard, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bankers_request_safety_check_assert.svh"

module brsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] cmd_i,
  input logic       result_valid_o,
  input logic [2:0] status_o,
  input logic [3:0] order_process_o,
  input logic [7:0] read_value_o,
  input logic       last_of_run_o
);
  import brsc_pkg::*;

  logic rd_take, err_out;

  assign rd_take = start && !busy && (cmd_i == CMD_READ);
  assign err_out = result_valid_o &&
                   ((status_o == ST_NEED) || (status_o == ST_AVAIL) ||
                    (status_o == ST_UNSAFE) || (status_o == ST_READ));

  `BRSC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !result_valid_o, "result during reset")
  `BRSC_ASSERT(a_read_latency, rd_take |=> ##1 result_valid_o, "read result missing")
  `BRSC_ASSERT(a_single_result, err_out |-> last_of_run_o && (order_process_o == 4'd0), "single result not last")
  `BRSC_ASSERT(a_grant_no_data, result_valid_o && (status_o != ST_READ) |-> read_value_o == 8'd0, "request result carries data")

endmodule

bind bankers_request_safety_check brsc_checker u_brsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .cmd_i           (cmd_i),
  .result_valid_o  (result_valid_o),
  .status_o        (status_o),
  .order_process_o (order_process_o),
  .read_value_o    (read_value_o),
  .last_of_run_o   (last_of_run_o)
);

`default_nettype wire

// ===== verif/bankers_request_safety_check_tb.sv =====
// ---------------------------------------------------------------------------
// bankers_request_safety_check_tb
// Self-checking bench for the resource guard: loads, reads and requests are
// driven through the command port, an in-bench model of the guard predicts
// every result, and each result strobe is compared field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module bankers_request_safety_check_tb;
  import brsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC = 16;
  localparam int NRES  = 8;

  typedef struct {
    brsc_status_e status;
    logic [3:0]   order_process;
    logic [7:0]   read_value;
    logic         last_of_run;
  } guard_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] cmd_i = '0;
  logic [3:0] process_i = '0;
  logic [2:0] resource_i = '0;
  logic [7:0] amount_i = '0;
  logic [1:0] table_select_i = '0;
  logic       final_element_i = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [4:0] cfg_wdata_i = '0;
  logic       result_valid_o;
  logic [2:0] status_o;
  logic [3:0] order_process_o;
  logic [7:0] read_value_o;
  logic       last_of_run_o;

  bankers_request_safety_check u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // guard state mirror
  int unsigned   units_free [NRES];
  int unsigned   max_claim  [NPROC*NRES];
  int unsigned   held       [NPROC*NRES];
  int unsigned   still_need [NPROC*NRES];
  int unsigned   asked      [NRES];
  logic [15:0]   retired;
  logic [4:0]    proc_cfg = 5'd16;
  logic [3:0]    res_cfg  = 4'd8;
  guard_result_t expected_results[$];
  int            fail_cnt = 0;

  function automatic int unsigned procs_used();
    return (proc_cfg == 0) ? 1 : (proc_cfg > NPROC) ? NPROC : proc_cfg;
  endfunction

  function automatic int unsigned res_used();
    return (res_cfg == 0) ? 1 : (res_cfg > NRES) ? NRES : res_cfg;
  endfunction

  function automatic void push_result(brsc_status_e st, int unsigned op, int unsigned rv,
                                      bit last);
    guard_result_t g;
    g.status = st;
    g.order_process = op[3:0];
    g.read_value = rv[7:0];
    g.last_of_run = last;
    expected_results.push_back(g);
  endfunction

  function automatic int unsigned sat(int unsigned a, int unsigned b, int unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic void evaluate_request(int unsigned pid);
    int unsigned n, m, cnt, nd, al, idx;
    int unsigned trial [NRES];
    int unsigned order [$];
    logic [15:0] active, done;
    bit all_asked, progress, ok, drained;
    brsc_status_e st;
    n = procs_used();
    m = res_used();
    if (pid >= n || retired[pid]) begin
      push_result(ST_NEED, 0, 0, 1);
      return;
    end
    for (int r = 0; r < m; r++) begin
      if (asked[r] > still_need[pid*NRES+r]) begin
        push_result(ST_NEED, 0, 0, 1);
        return;
      end
      if (asked[r] > units_free[r]) begin
        push_result(ST_AVAIL, 0, 0, 1);
        return;
      end
    end
    // trial grant
    active = '0;
    for (int i = 0; i < n; i++) if (!retired[i]) active[i] = 1'b1;
    done = '0;
    all_asked = 1;
    for (int r = 0; r < m; r++) begin
      trial[r] = units_free[r] - asked[r];
      if (still_need[pid*NRES+r] != asked[r]) all_asked = 0;
    end
    if (all_asked) begin
      order.push_back(pid);
      done[pid] = 1'b1;
      for (int r = 0; r < m; r++)
        trial[r] = sat(trial[r], held[pid*NRES+r] + asked[r], 511);
    end
    progress = 1;
    while (progress && (active & ~done) != 0) begin
      progress = 0;
      for (int i = 0; i < n; i++) begin
        if (!active[i] || done[i]) continue;
        ok = 1;
        for (int r = 0; r < m; r++) begin
          nd = still_need[i*NRES+r];
          if (i == pid) nd -= asked[r];
          if (nd > trial[r]) ok = 0;
        end
        if (!ok) continue;
        for (int r = 0; r < m; r++) begin
          al = held[i*NRES+r];
          if (i == pid) al += asked[r];
          trial[r] = sat(trial[r], al, 511);
        end
        done[i] = 1'b1;
        if (order.size() < NPROC) order.push_back(i);
        progress = 1;
      end
    end
    if ((active & ~done) != 0) begin
      push_result(ST_UNSAFE, 0, 0, 1);
      return;
    end
    // commit
    drained = 1;
    for (int r = 0; r < m; r++) begin
      idx = pid*NRES + r;
      units_free[r] -= asked[r];
      held[idx] += asked[r];
      still_need[idx] -= asked[r];
      if (still_need[idx] != 0) drained = 0;
    end
    if (drained) begin
      retired[pid] = 1'b1;
      for (int r = 0; r < m; r++) begin
        idx = pid*NRES + r;
        units_free[r] = sat(units_free[r], held[idx], 255);
        held[idx] = 0;
      end
    end
    st = drained ? ST_RETIRE : ST_GRANT;
    cnt = order.size();
    foreach (order[k]) push_result(st, order[k], 0, k + 1 == cnt);
  endfunction

  function automatic void predict_command(logic [2:0] cmd, logic [3:0] p, logic [2:0] r,
                                          logic [7:0] amt, logic [1:0] sel, logic fin);
    int unsigned idx, v;
    idx = p*NRES + r;
    case (cmd)
      CMD_LOAD_AVAIL: units_free[r] = amt;
      CMD_LOAD_MAX, CMD_LOAD_ALLOC: begin
        if (cmd == CMD_LOAD_MAX) max_claim[idx] = amt;
        else held[idx] = amt;
        still_need[idx] = (max_claim[idx] > held[idx]) ? max_claim[idx] - held[idx] : 0;
      end
      CMD_REQUEST: begin
        asked[r] = amt;
        if (fin) begin
          evaluate_request(p);
          foreach (asked[i]) asked[i] = 0;
        end
      end
      CMD_READ: begin
        case (sel)
          SEL_AVAIL: v = units_free[r];
          SEL_MAX:   v = max_claim[idx];
          SEL_ALLOC: v = held[idx];
          default:   v = still_need[idx];
        endcase
        push_result(ST_READ, 0, v, 1);
      end
      default: ;
    endcase
  endfunction

  // Drive one transaction; start stays high until the caller idles or sends again.
  task automatic send_cmd(logic [2:0] cmd, logic [3:0] p, logic [2:0] r, logic [7:0] amt,
                          logic [1:0] sel, logic fin);
    bit taken;
    start <= 1'b1;
    cmd_i <= cmd;
    process_i <= p;
    resource_i <= r;
    amount_i <= amt;
    table_select_i <= sel;
    final_element_i <= fin;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    predict_command(cmd, p, r, amt, sel, fin);
  endtask

  task automatic idle_gap();
    int unsigned k, len;
    k = $urandom_range(0, 99);
    len = (k < 60) ? 0 : (k < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    do @(negedge clk_i); while (busy);
    repeat (20) @(posedge clk_i);
  endtask

  // one write, then write enable low again so back-to-back writes stay apart
  task automatic write_cfg(brsc_cfg_e index, logic [4:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (index == CFG_NUM_PROCESSES) proc_cfg = value;
    else res_cfg = value[3:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // request of one process: elements for a set of resources, last one flagged
  task automatic send_request(logic [3:0] p, int unsigned amounts [NRES], int unsigned cnt);
    for (int r = 0; r < cnt; r++) begin
      send_cmd(CMD_REQUEST, p, r[2:0], amounts[r][7:0], $urandom, r == cnt - 1);
      idle_gap();
    end
  endtask

  task automatic test_directed();
    write_cfg(CFG_NUM_PROCESSES, 5'd3);
    write_cfg(CFG_NUM_RESOURCES, 4'd2);
    send_cmd(CMD_LOAD_AVAIL, 0, 0, 8'd3, SEL_AVAIL, 0);
    send_cmd(CMD_LOAD_AVAIL, 0, 1, 8'd3, SEL_AVAIL, 0);
    send_cmd(CMD_LOAD_MAX, 0, 0, 8'd2, SEL_AVAIL, 0);
    send_cmd(CMD_LOAD_MAX, 0, 1, 8'd2, SEL_AVAIL, 0);
    send_cmd(CMD_LOAD_ALLOC, 0, 0, 8'd1, SEL_AVAIL, 0);
    send_cmd(CMD_LOAD_MAX, 1, 0, 8'd4, SEL_AVAIL, 0);
    send_cmd(CMD_LOAD_ALLOC, 1, 1, 8'd255, SEL_AVAIL, 0);  // allocation above maximum
    send_cmd(CMD_LOAD_MAX, 2, 0, 8'd9, SEL_AVAIL, 0);
    send_cmd(CMD_READ, 1, 1, 8'd0, SEL_NEED, 0);
    send_cmd(CMD_READ, 1, 1, 8'd0, SEL_ALLOC, 0);
    send_cmd(CMD_READ, 0, 0, 8'd0, SEL_MAX, 0);
    send_cmd(CMD_READ, 15, 7, 8'd0, SEL_AVAIL, 0);
    send_cmd(CMD_READ, 9, 5, 8'd0, SEL_NEED, 0);          // never loaded entry
    send_cmd(3'd7, 0, 0, 8'd0, SEL_AVAIL, 0);              // unknown command
    send_cmd(CMD_REQUEST, 0, 0, 8'd5, SEL_AVAIL, 1);       // over need
    send_cmd(CMD_REQUEST, 1, 0, 8'd3, SEL_AVAIL, 0);       // unsafe: p2 can never finish
    send_cmd(CMD_REQUEST, 1, 1, 8'd0, SEL_AVAIL, 1);
    send_cmd(CMD_LOAD_MAX, 2, 0, 8'd0, SEL_AVAIL, 0);
    send_cmd(CMD_REQUEST, 1, 0, 8'd3, SEL_AVAIL, 1);       // unsafe: p0 and p1 cannot finish
    send_cmd(CMD_REQUEST, 0, 0, 8'd1, SEL_AVAIL, 0);       // completes and retires
    send_cmd(CMD_REQUEST, 0, 1, 8'd2, SEL_AVAIL, 1);
    send_cmd(CMD_LOAD_AVAIL, 0, 0, 8'd255, SEL_AVAIL, 0);
    send_cmd(CMD_REQUEST, 0, 0, 8'd1, SEL_AVAIL, 0);       // retired process
    send_cmd(CMD_REQUEST, 0, 1, 8'd2, SEL_AVAIL, 1);
    send_cmd(CMD_REQUEST, 0, 0, 8'd0, SEL_AVAIL, 1);       // retired process
    send_cmd(CMD_REQUEST, 14, 0, 8'd0, SEL_AVAIL, 1);      // process out of range
    drain_and_settle();
  endtask

  task automatic test_random_phase(logic [4:0] np, logic [3:0] nr, int unsigned items);
    int unsigned n, m, k, sent, cnt, e, nl;
    int unsigned amounts [NRES];
    logic [3:0] p;
    write_cfg(CFG_NUM_PROCESSES, np);
    write_cfg(CFG_NUM_RESOURCES, nr);
    n = procs_used();
    m = res_used();
    for (int r = 0; r < m; r++)
      send_cmd(CMD_LOAD_AVAIL, 0, 3'(r), 8'($urandom_range(2, 12)), 0, 0);
    // load every entry of a small table, a random subset of a large one
    nl = (n * m < 12) ? n * m : 12;
    for (int j = 0; j < nl; j++) begin
      e = (n * m <= 12) ? j : $urandom_range(0, n * m - 1);
      send_cmd(CMD_LOAD_MAX, 4'(e / m), 3'(e % m), 8'($urandom_range(0, 6)), 0, 0);
      send_cmd(CMD_LOAD_ALLOC, 4'(e / m), 3'(e % m), 8'($urandom_range(0, 2)), 0, 0);
    end
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(0, 99);
      p = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, n - 1);
      if (k < 65) begin
        cnt = $urandom_range(1, m);
        foreach (amounts[r])
          amounts[r] = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3);
        send_request(p, amounts, cnt);
      end else if (k < 85) begin
        send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (k < 95) begin
        send_cmd($urandom_range(0, 2), p, $urandom_range(0, m - 1),
                 ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8), 0, 0);
      end else begin
        send_cmd($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      idle_gap();
      sent++;
    end
    drain_and_settle();
  endtask

  always @(posedge clk_i) begin
    guard_result_t g;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d order %0d", status_o, order_process_o);
        fail_cnt++;
      end else begin
        g = expected_results.pop_front();
        if (status_o !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, status_o);
          fail_cnt++;
        end
        if (order_process_o !== g.order_process) begin
          $error("order_process: expected %0d, got %0d", g.order_process, order_process_o);
          fail_cnt++;
        end
        if (read_value_o !== g.read_value) begin
          $error("read_value: expected %0d, got %0d", g.read_value, read_value_o);
          fail_cnt++;
        end
        if (last_of_run_o !== g.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", g.last_of_run, last_of_run_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    foreach (units_free[i]) units_free[i] = 0;
    foreach (max_claim[i]) begin
      max_claim[i] = 0;
      held[i] = 0;
      still_need[i] = 0;
    end
    foreach (asked[i]) asked[i] = 0;
    retired = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(5'd4, 4'd2, 30);
    test_random_phase(5'd1, 4'd1, 15);
    test_random_phase(5'd16, 4'd8, 15);
    test_random_phase(5'd0, 4'd0, 10);
    test_random_phase(5'd31, 4'd15, 10);
    test_random_phase(5'd6, 4'd3, 25);
    test_random_phase($urandom_range(2, 10), $urandom_range(1, 4), 30);
    if (expected_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/brsc_pkg.sv
rtl/core/bankers_request_safety_check.sv
rtl/core/brsc_checker.sv
verif/bankers_request_safety_check_tb.sv
